[sv/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg
// Types and codes shared by the adaptive step controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  localparam int EST_W   = 24;
  localparam int TIME_W  = 32;
  localparam int STEP_W  = 15;
  localparam int SLEN_W  = 16;
  localparam int CNT_W   = 14;
  localparam int ERR_W   = 3;

  localparam logic [EST_W-1:0]  ONE_Q16        = 24'd65536;
  localparam logic [EST_W-1:0]  TENTH_Q16_MAX  = 24'd6553;
  localparam logic [STEP_W-1:0] MAX_STEP_RESET = 15'd25000;
  localparam logic [STEP_W-1:0] HALF_RESET     = 15'd25000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TRIAL  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic [1:0] CMD_TRIAL  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_DONE   = 2'd2;
  localparam logic [1:0] CMD_FAIL   = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_EPOCH    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BOUND    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NONFIN   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_COMMIT   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_ACCURACY = 3'd5;

  localparam logic CFG_EPOCH    = 1'b0;
  localparam logic CFG_MAX_STEP = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [EST_W-1:0] estimate;
    logic             estimate_invalid;
    logic             commit_failed;
  } item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] trial_start;
    logic [STEP_W-1:0] trial_step;
    logic [ERR_W-1:0]  error_code;
    logic [CNT_W-1:0]  accepted_count;
    logic [CNT_W-1:0]  rejected_count;
    logic [STEP_W-1:0] min_half_step;
    logic [EST_W-1:0]  max_estimate;
  } result_t;

endpackage

`default_nettype wire

[sv/asc_in_reg.sv]
// ----------------------------------------------------------------------------
// asc_in_reg
// Input register: holds one accepted beat until the engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_in_reg
  import asc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[sv/asc_engine.sv]
// ----------------------------------------------------------------------------
// asc_engine
// Epoch state and step decision logic, one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_engine
  import asc_pkg::*;
#(
  parameter int STEP_LIMIT    = 25000,
  parameter int ATTEMPT_LIMIT = 10000,
  parameter int MIN_STEP      = 200
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire item_t             item,
  input  wire logic [TIME_W-1:0] cfg_epoch,
  input  wire logic [STEP_W-1:0] cfg_max_step,
  output logic                   res_valid,
  output result_t                res
);

  localparam int AC_W = $clog2(ATTEMPT_LIMIT + 2);

  typedef enum logic [1:0] {PH_IDLE, PH_TRIAL, PH_COMMIT} phase_t;

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] time_left_r, time_left_nxt;
  logic [TIME_W-1:0] time_used_r, time_used_nxt;
  logic [SLEN_W-1:0] step_r, step_nxt;
  logic [AC_W-1:0]   attempt_r, attempt_nxt;
  logic [CNT_W-1:0]  accepted_r, accepted_nxt;
  logic [CNT_W-1:0]  rejected_r, rejected_nxt;
  logic [STEP_W-1:0] half_r, half_nxt;
  logic [EST_W-1:0]  largest_r, largest_nxt;
  logic [EST_W-1:0]  held_r, held_nxt;

  logic              run_next;
  logic [1:0]        cmd;
  logic [ERR_W-1:0]  err;
  logic [TIME_W-1:0] rem;
  logic [SLEN_W-1:0] half_step;
  logic [SLEN_W:0]   grown;

  always_comb begin
    phase_nxt     = phase_r;
    time_left_nxt = time_left_r;
    time_used_nxt = time_used_r;
    step_nxt      = step_r;
    attempt_nxt   = attempt_r;
    accepted_nxt  = accepted_r;
    rejected_nxt  = rejected_r;
    half_nxt      = half_r;
    largest_nxt   = largest_r;
    held_nxt      = held_r;
    run_next      = 1'b0;
    res_valid     = 1'b0;
    cmd           = CMD_TRIAL;
    err           = ERR_NONE;
    rem           = '0;
    half_step     = step_r >> 1;
    grown         = '0;

    case (item.operation)
      OP_START: begin
        if (cfg_epoch == '0 || cfg_max_step == '0 ||
            cfg_max_step > STEP_W'(STEP_LIMIT)) begin
          phase_nxt = PH_IDLE;
          cmd       = CMD_FAIL;
          err       = ERR_EPOCH;
          res_valid = 1'b1;
        end else begin
          time_left_nxt = cfg_epoch;
          time_used_nxt = '0;
          if (TIME_W'(cfg_max_step) < cfg_epoch) begin
            step_nxt = SLEN_W'(cfg_max_step);
          end else begin
            step_nxt = cfg_epoch[SLEN_W-1:0];
          end
          attempt_nxt  = '0;
          accepted_nxt = '0;
          rejected_nxt = '0;
          half_nxt     = STEP_W'(STEP_LIMIT);
          largest_nxt  = '0;
          held_nxt     = '0;
          run_next     = 1'b1;
        end
      end
      OP_TRIAL: begin
        if (phase_r == PH_TRIAL) begin
          if (item.estimate_invalid) begin
            phase_nxt = PH_IDLE;
            cmd       = CMD_FAIL;
            err       = ERR_NONFIN;
            res_valid = 1'b1;
          end else if (item.estimate <= ONE_Q16) begin
            held_nxt  = item.estimate;
            phase_nxt = PH_COMMIT;
            cmd       = CMD_COMMIT;
            res_valid = 1'b1;
          end else begin
            rejected_nxt = rejected_r + 1'b1;
            if (half_step < SLEN_W'(MIN_STEP)) begin
              phase_nxt = PH_IDLE;
              cmd       = CMD_FAIL;
              err       = ERR_ACCURACY;
              res_valid = 1'b1;
            end else begin
              step_nxt = half_step;
              run_next = 1'b1;
            end
          end
        end
      end
      OP_COMMIT: begin
        if (phase_r == PH_COMMIT) begin
          if (item.commit_failed) begin
            phase_nxt = PH_IDLE;
            cmd       = CMD_FAIL;
            err       = ERR_COMMIT;
            res_valid = 1'b1;
          end else begin
            time_used_nxt = time_used_r + TIME_W'(step_r);
            time_left_nxt = time_left_r - TIME_W'(step_r);
            accepted_nxt  = accepted_r + 1'b1;
            if (half_step < SLEN_W'(half_r)) begin
              half_nxt = half_step[STEP_W-1:0];
            end
            if (held_r > largest_r) begin
              largest_nxt = held_r;
            end
            if (held_r <= TENTH_Q16_MAX) begin
              grown = {step_r, 1'b0};
            end else begin
              grown = {1'b0, step_r};
            end
            if (grown < (SLEN_W+1)'(cfg_max_step)) begin
              step_nxt = grown[SLEN_W-1:0];
            end else begin
              step_nxt = SLEN_W'(cfg_max_step);
            end
            run_next = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // request the next trial, close the epoch, or fail on a step or attempt bound
    if (run_next) begin
      res_valid = 1'b1;
      if (time_left_nxt == '0) begin
        phase_nxt = PH_IDLE;
        cmd       = CMD_DONE;
      end else begin
        if (TIME_W'(step_nxt) > time_left_nxt) begin
          step_nxt = time_left_nxt[SLEN_W-1:0];
        end
        rem = time_left_nxt - TIME_W'(step_nxt);
        if (rem != '0 && rem < TIME_W'(MIN_STEP)) begin
          step_nxt = time_left_nxt[SLEN_W-1:0];
        end
        if (step_nxt < SLEN_W'(2)) begin
          phase_nxt = PH_IDLE;
          cmd       = CMD_FAIL;
          err       = ERR_BOUND;
        end else begin
          attempt_nxt = attempt_r + 1'b1;
          if (attempt_nxt > AC_W'(ATTEMPT_LIMIT)) begin
            phase_nxt = PH_IDLE;
            cmd       = CMD_FAIL;
            err       = ERR_BOUND;
          end else begin
            phase_nxt = PH_TRIAL;
            cmd       = CMD_TRIAL;
          end
        end
      end
    end

    res.command        = cmd;
    res.trial_start    = time_used_nxt;
    res.trial_step     = step_nxt[STEP_W-1:0];
    res.error_code     = err;
    res.accepted_count = accepted_nxt;
    res.rejected_count = rejected_nxt;
    res.min_half_step  = half_nxt;
    res.max_estimate   = largest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      time_left_r <= '0;
      time_used_r <= '0;
      step_r      <= '0;
      attempt_r   <= '0;
      accepted_r  <= '0;
      rejected_r  <= '0;
      half_r      <= HALF_RESET;
      largest_r   <= '0;
      held_r      <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      time_left_r <= time_left_nxt;
      time_used_r <= time_used_nxt;
      step_r      <= step_nxt;
      attempt_r   <= attempt_nxt;
      accepted_r  <= accepted_nxt;
      rejected_r  <= rejected_nxt;
      half_r      <= half_nxt;
      largest_r   <= largest_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/adaptive_step_controller.sv]
// path: an accepted beat passes from the input register through the
// combinational engine; its result, if any, goes to the output register
// throughput: one item per cycle, single engine pass, stalled by out_ready
// reset: synchronous active-low rst_n clears both channels and the epoch
// state; max_step returns to 25000 and the epoch duration to zero
// ----------------------------------------------------------------------------
// adaptive_step_controller
// Top level: input register, step engine, output register and config regs.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_step_controller
  import asc_pkg::*;
#(
  parameter int STEP_LIMIT    = 25000,
  parameter int ATTEMPT_LIMIT = 10000,
  parameter int MIN_STEP      = 200
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic [EST_W-1:0]  in_estimate,
  input  wire logic              in_estimate_invalid,
  input  wire logic              in_commit_failed,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_command,
  output logic [TIME_W-1:0]      out_trial_start,
  output logic [STEP_W-1:0]      out_trial_step,
  output logic [ERR_W-1:0]       out_error_code,
  output logic [CNT_W-1:0]       out_accepted_count,
  output logic [CNT_W-1:0]       out_rejected_count,
  output logic [STEP_W-1:0]      out_min_half_step,
  output logic [EST_W-1:0]       out_max_estimate,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [TIME_W-1:0] cfg_wdata
);

  logic [TIME_W-1:0] epoch_r;
  logic [STEP_W-1:0] max_step_r;
  item_t             in_item;
  item_t             item;
  logic              item_valid;
  logic              take;
  logic              res_valid;
  result_t           res;
  logic              out_valid_r;
  result_t           out_r;

  assign in_item.operation        = in_operation;
  assign in_item.estimate         = in_estimate;
  assign in_item.estimate_invalid = in_estimate_invalid;
  assign in_item.commit_failed    = in_commit_failed;

  assign take = item_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r    <= '0;
      max_step_r <= MAX_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPOCH:    epoch_r    <= cfg_wdata;
        CFG_MAX_STEP: max_step_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  asc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  asc_engine #(
    .STEP_LIMIT    (STEP_LIMIT),
    .ATTEMPT_LIMIT (ATTEMPT_LIMIT),
    .MIN_STEP      (MIN_STEP)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (take),
    .item         (item),
    .cfg_epoch    (epoch_r),
    .cfg_max_step (max_step_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command        = out_r.command;
  assign out_trial_start    = out_r.trial_start;
  assign out_trial_step     = out_r.trial_step;
  assign out_error_code     = out_r.error_code;
  assign out_accepted_count = out_r.accepted_count;
  assign out_rejected_count = out_r.rejected_count;
  assign out_min_half_step  = out_r.min_half_step;
  assign out_max_estimate   = out_r.max_estimate;

endmodule

`default_nettype wire

[sv/asc_checker.sv]
// ----------------------------------------------------------------------------
// asc_checker
// Port-level checks on the result channel of the adaptive step controller.
// ----------------------------------------------------------------------------
`default_nettype none

module asc_checker
  import asc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_command,
  input wire logic [TIME_W-1:0] out_trial_start,
  input wire logic [ERR_W-1:0]  out_error_code
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
      $stable(out_trial_start) && $stable(out_error_code))
    else $error("stalled result beat changed");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // only a failure carries an error code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != CMD_FAIL |-> out_error_code == ERR_NONE)
    else $error("error code on a non-failure beat");

  // a failure always names its cause
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command == CMD_FAIL |->
      (out_error_code == ERR_EPOCH || out_error_code == ERR_BOUND ||
       out_error_code == ERR_NONFIN || out_error_code == ERR_COMMIT ||
       out_error_code == ERR_ACCURACY))
    else $error("failure beat without a valid cause");

endmodule

bind adaptive_step_controller asc_checker u_asc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_command     (out_command),
  .out_trial_start (out_trial_start),
  .out_error_code  (out_error_code)
);

`default_nettype wire
